FILE: rtl/sfr_pkg.sv
package sfr_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_WAIT_WAKE = 2'd0,
    PH_COMMAND   = 2'd1,
    PH_LENGTH    = 2'd2,
    PH_PAYLOAD   = 2'd3
  } sfr_phase_e;

  // decoded command
  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_REPLY  = 2'd1,
    CMD_NONE   = 2'd3
  } sfr_cmd_e;

  // result event codes
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_REJECT   = 2'd2,
    EV_REPLY    = 2'd3
  } sfr_event_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WAKE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UPDATE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPLY  = 2'd2;

  localparam logic [7:0]  UPDATE_LEN  = 8'h06;
  localparam logic [7:0]  REPLY_LEN   = 8'h01;
  localparam logic [15:0] ANGLE_LIMIT = 16'd3600;
  localparam int unsigned PayloadDepth = 6;

  typedef struct packed {
    sfr_event_e         frame_event;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [11:0]        heading;
    logic               position_valid;
    logic [7:0]         reply_flags;
  } sfr_result_t;

endpackage

FILE: rtl/sfr_if.sv
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic [7:0] clear_mask;

  modport source (output valid, func, rx_byte, clear_mask, input ready);
  modport sink (input valid, func, rx_byte, clear_mask, output ready);
endinterface

interface sfr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_event;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [11:0]        heading;
  logic               position_valid;
  logic [7:0]         reply_flags;

  modport source (output valid, frame_event, pos_x, pos_y, heading, position_valid,
                  reply_flags, input ready);
  modport sink (input valid, frame_event, pos_x, pos_y, heading, position_valid,
                reply_flags, output ready);
endinterface

interface sfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::CfgIdxW-1:0]   index;
  logic [7:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sensor_frame_receiver.sv
// output: a result goes to the output register, or to the skid stage on a stall
// throughput: one input beat per cycle while the skid stage is empty; an output
//   register plus a one-entry skid stage keep input ready high while one result waits downstream
// reset (rst_ni low, asynchronous): parser waits for a wake byte, held position,
//   heading, position flag, reply flags and code registers clear to zero
module sensor_frame_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfr_cfg_if.sink      cfg_i,
  sfr_in_if.sink       in_i,
  sfr_out_if.source    out_o
);

  // ---------------------------------------------------------------------------
  // configuration registers, always ready
  // ---------------------------------------------------------------------------
  logic [7:0] wake_code_q, update_code_q, reply_code_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_code_q   <= '0;
      update_code_q <= '0;
      reply_code_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        sfr_pkg::CFG_WAKE:   wake_code_q   <= cfg_i.data;
        sfr_pkg::CFG_UPDATE: update_code_q <= cfg_i.data;
        sfr_pkg::CFG_REPLY:  reply_code_q  <= cfg_i.data;
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  sfr_pkg::sfr_phase_e phase_q, phase_d;
  sfr_pkg::sfr_cmd_e   cmd_q, cmd_d;
  logic [2:0]          cnt_q, cnt_d;

  // payload bytes of the frame in progress, no reset needed
  logic [7:0] payload_q [sfr_pkg::PayloadDepth];
  logic       pay_we;

  // held results
  logic signed [15:0] held_x_q, held_x_d;
  logic signed [15:0] held_y_q, held_y_d;
  logic [11:0]        held_angle_q, held_angle_d;
  logic               valid_flag_q, valid_flag_d;
  logic [7:0]         ack_flags_q, ack_flags_d;

  sfr_pkg::sfr_event_e ev;
  logic                accept;
  logic [7:0]          rx_byte;
  logic [7:0]          frame_len;
  logic [2:0]          cnt_inc;
  logic [15:0]         angle_raw;

  assign accept    = in_i.valid && in_i.ready;
  assign rx_byte   = in_i.rx_byte;
  assign frame_len = (cmd_q == sfr_pkg::CMD_UPDATE) ? sfr_pkg::UPDATE_LEN
                                                    : sfr_pkg::REPLY_LEN;
  assign cnt_inc   = cnt_q + 3'd1;
  // angle is the last two bytes; the low one is the byte arriving now
  assign angle_raw = {payload_q[4], rx_byte};

  always_comb begin
    phase_d      = phase_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    held_angle_d = held_angle_q;
    valid_flag_d = valid_flag_q;
    ack_flags_d  = ack_flags_q;
    pay_we       = 1'b0;
    ev           = sfr_pkg::EV_NONE;

    if (in_i.func) begin
      // software clear of reply bits, parser untouched
      ack_flags_d = ack_flags_q & ~in_i.clear_mask;
    end else begin
      unique case (phase_q)
        sfr_pkg::PH_WAIT_WAKE: begin
          if (rx_byte == wake_code_q) begin
            cmd_d   = sfr_pkg::CMD_NONE;
            cnt_d   = '0;
            phase_d = sfr_pkg::PH_COMMAND;
          end
        end
        sfr_pkg::PH_COMMAND: begin
          // update code takes priority when both codes match
          priority if (rx_byte == update_code_q) begin
            cmd_d   = sfr_pkg::CMD_UPDATE;
            phase_d = sfr_pkg::PH_LENGTH;
          end else if (rx_byte == reply_code_q) begin
            cmd_d   = sfr_pkg::CMD_REPLY;
            phase_d = sfr_pkg::PH_LENGTH;
          end else begin
            cmd_d   = sfr_pkg::CMD_NONE;
            phase_d = sfr_pkg::PH_WAIT_WAKE;
          end
        end
        sfr_pkg::PH_LENGTH: begin
          if (cmd_q == sfr_pkg::CMD_NONE || rx_byte != frame_len) begin
            phase_d = sfr_pkg::PH_WAIT_WAKE;
          end else begin
            phase_d = sfr_pkg::PH_PAYLOAD;
          end
        end
        sfr_pkg::PH_PAYLOAD: begin
          if (cmd_q == sfr_pkg::CMD_NONE || cnt_q >= 3'd6) begin
            phase_d = sfr_pkg::PH_WAIT_WAKE;
          end else begin
            pay_we = 1'b1;
            cnt_d  = cnt_inc;
            if (cnt_inc >= frame_len[2:0]) begin
              phase_d = sfr_pkg::PH_WAIT_WAKE;
              if (cmd_q == sfr_pkg::CMD_UPDATE) begin
                if (angle_raw < sfr_pkg::ANGLE_LIMIT) begin
                  held_y_d     = {payload_q[0], payload_q[1]};
                  held_x_d     = {payload_q[2], payload_q[3]};
                  held_angle_d = angle_raw[11:0];
                  valid_flag_d = 1'b1;
                  ev           = sfr_pkg::EV_ACCEPT;
                end else begin
                  valid_flag_d = 1'b0;
                  ev           = sfr_pkg::EV_REJECT;
                end
              end else begin
                // reply byte is the current byte; out-of-range index sets nothing
                if (rx_byte < 8'd8) begin
                  ack_flags_d = ack_flags_q | (8'd1 << rx_byte[2:0]);
                end
                ev = sfr_pkg::EV_REPLY;
              end
            end
          end
        end
        default: phase_d = sfr_pkg::PH_WAIT_WAKE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfr_pkg::PH_WAIT_WAKE;
      cmd_q        <= sfr_pkg::CMD_NONE;
      cnt_q        <= '0;
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_angle_q <= '0;
      valid_flag_q <= 1'b0;
      ack_flags_q  <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      cmd_q        <= cmd_d;
      cnt_q        <= cnt_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      held_angle_q <= held_angle_d;
      valid_flag_q <= valid_flag_d;
      ack_flags_q  <= ack_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pay_we) begin
      payload_q[cnt_q] <= rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // result snapshot: every field shows the state after the beat
  // ---------------------------------------------------------------------------
  sfr_pkg::sfr_result_t res;

  always_comb begin
    res.frame_event    = ev;
    res.pos_x          = held_x_d;
    res.pos_y          = held_y_d;
    res.heading        = held_angle_d;
    res.position_valid = valid_flag_d;
    res.reply_flags    = ack_flags_d;
  end

  // ---------------------------------------------------------------------------
  // output register with skid stage
  // ---------------------------------------------------------------------------
  sfr_pkg::sfr_result_t out_q, out_d, skid_q, skid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  logic                 out_take;

  assign out_take   = out_valid_q && out_o.ready;
  assign in_i.ready = !skid_valid_q;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_take) begin
      priority if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      // downstream stalled, park the new result
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.frame_event    = out_q.frame_event;
  assign out_o.pos_x          = out_q.pos_x;
  assign out_o.pos_y          = out_q.pos_y;
  assign out_o.heading        = out_q.heading;
  assign out_o.position_valid = out_q.position_valid;
  assign out_o.reply_flags    = out_q.reply_flags;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid only fills behind a held output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while output register is empty");

  // a clear beat leaves the parser where it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.func) |=> ($stable(phase_q) && $stable(cnt_q)))
    else $error("clear beat moved the frame parser");

  // an accepted position always carries a valid in-range heading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_event == sfr_pkg::EV_ACCEPT) |->
      (out_q.position_valid && ({4'd0, out_q.heading} < sfr_pkg::ANGLE_LIMIT)))
    else $error("accepted position with bad heading or flag");

  // held angle never leaves the legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'd0, held_angle_q} < sfr_pkg::ANGLE_LIMIT)
    else $error("held heading out of range");

endmodule
